[src/s_expression_lexer_defines.svh]
// assertion macros used by the checker file
`ifndef S_EXPRESSION_LEXER_DEFINES_SVH
`define S_EXPRESSION_LEXER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SEXL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sexl assertion failed");

// next-cycle implication, disabled during reset
`define SEXL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sexl assertion failed");

`endif

[src/sexl_pkg.sv]
package sexl_pkg;

	// token classes
	typedef enum logic [2:0] {
		CLS_OPEN   = 3'd0,
		CLS_CLOSE  = 3'd1,
		CLS_SYMBOL = 3'd2,
		CLS_INT    = 3'd3,
		CLS_CHAR   = 3'd4,
		CLS_STRING = 3'd5,
		CLS_BOOL   = 3'd6,
		CLS_NULL   = 3'd7
	} class_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_OPEN_STR   = 3'd1,
		ERR_OPEN_CHAR  = 3'd2,
		ERR_CHAR_LEN   = 3'd3,
		ERR_BAD_INT    = 3'd4
	} err_t;

	// one output record
	typedef struct packed {
		logic               record_kind;
		logic [7:0]         token_byte;
		class_t             token_class;
		logic signed [31:0] int_value;
		logic               bool_value;
		err_t               error_code;
	} rec_t;

	// state of the atom being collected
	typedef struct packed {
		logic [2:0]  length;
		logic        first_is_sign;
		logic        negative_sign;
		logic        numeric_start;
		logic        all_digits;
		logic [31:0] acc;
		logic [2:0]  kw_hits;
	} atom_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam int KW_COUNT = 3;
	localparam logic [2:0] KW_LEN_TRUE  = 3'd4;
	localparam logic [2:0] KW_LEN_FALSE = 3'd5;
	localparam logic [2:0] KW_LEN_NULL  = 3'd4;

	// keyword lengths by index: true, false, null
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		case (k)
			2'd0: kw_len = KW_LEN_TRUE;
			2'd1: kw_len = KW_LEN_FALSE;
			default: kw_len = KW_LEN_NULL;
		endcase
	endfunction

	// keyword text by index and position
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
		case ({k, p})
			{2'd0, 3'd0}: kw_char = "t";
			{2'd0, 3'd1}: kw_char = "r";
			{2'd0, 3'd2}: kw_char = "u";
			{2'd0, 3'd3}: kw_char = "e";
			{2'd1, 3'd0}: kw_char = "f";
			{2'd1, 3'd1}: kw_char = "a";
			{2'd1, 3'd2}: kw_char = "l";
			{2'd1, 3'd3}: kw_char = "s";
			{2'd1, 3'd4}: kw_char = "e";
			{2'd2, 3'd0}: kw_char = "n";
			{2'd2, 3'd1}: kw_char = "u";
			{2'd2, 3'd2}: kw_char = "l";
			{2'd2, 3'd3}: kw_char = "l";
			default: kw_char = 8'h00;
		endcase
	endfunction

	function automatic atom_t atom_clear();
		atom_t a;
		a = '0;
		a.all_digits = 1'b1;
		a.kw_hits = 3'b111;
		return a;
	endfunction

	function automatic rec_t rec_make(input logic rk, input logic [7:0] b, input class_t cls,
			input logic signed [31:0] iv, input logic bv, input err_t err);
		rec_t r;
		r.record_kind = rk;
		r.token_byte  = b;
		r.token_class = cls;
		r.int_value   = iv;
		r.bool_value  = bv;
		r.error_code  = err;
		return r;
	endfunction

	// add one byte to the atom
	function automatic atom_t atom_push(input atom_t a, input logic [7:0] c);
		atom_t n;
		logic dig;
		logic [31:0] digit;
		logic [2:0] p;
		n = a;
		p = a.length;
		dig = (c >= CH_ZERO) && (c <= CH_NINE);
		digit = {24'd0, c - CH_ZERO};
		if (p == 3'd0) begin
			n.first_is_sign = (c == CH_PLUS) || (c == CH_MINUS);
			n.negative_sign = (c == CH_MINUS);
			n.numeric_start = dig;
			n.all_digits = dig || n.first_is_sign;
			n.acc = dig ? digit : 32'd0;
		end else begin
			if (p == 3'd1 && a.first_is_sign && dig)
				n.numeric_start = 1'b1;
			if (dig)
				n.acc = (a.acc << 3) + (a.acc << 1) + digit;
			else
				n.all_digits = 1'b0;
		end
		// drop keyword candidates that no longer match
		for (int k = 0; k < KW_COUNT; k++) begin
			if (p >= kw_len(2'(k)) || kw_char(2'(k), p) != c)
				n.kw_hits[k] = 1'b0;
		end
		n.length = (p < 3'd7) ? p + 3'd1 : 3'd7;
		return n;
	endfunction

	// end record of a finished atom
	function automatic rec_t atom_finish(input atom_t a);
		rec_t r;
		if (a.kw_hits[0] && a.length == KW_LEN_TRUE)
			r = rec_make(1'b1, 8'd0, CLS_BOOL, 32'sd0, 1'b1, ERR_OK);
		else if (a.kw_hits[1] && a.length == KW_LEN_FALSE)
			r = rec_make(1'b1, 8'd0, CLS_BOOL, 32'sd0, 1'b0, ERR_OK);
		else if (a.kw_hits[2] && a.length == KW_LEN_NULL)
			r = rec_make(1'b1, 8'd0, CLS_NULL, 32'sd0, 1'b0, ERR_OK);
		else if (a.numeric_start) begin
			if (a.all_digits)
				r = rec_make(1'b1, 8'd0, CLS_INT,
					a.negative_sign ? $signed(32'd0 - a.acc) : $signed(a.acc), 1'b0, ERR_OK);
			else
				r = rec_make(1'b1, 8'd0, CLS_INT, 32'sd0, 1'b0, ERR_BAD_INT);
		end else
			r = rec_make(1'b1, 8'd0, CLS_SYMBOL, 32'sd0, 1'b0, ERR_OK);
		return r;
	endfunction

endpackage

[src/s_expression_lexer.sv]
// s-expression lexer
// input channel (char_valid/char_ready): one text byte per transaction, kind = 0,
// or an end-of-text marker, kind = 1, whose char_code is ignored.
// output channel (record_valid/record_ready): token byte records and end records
// carrying token class, integer value, bool value and error code.
// throughput: one input transaction per cycle while char_ready is high. each byte
// is lexed in a single pass of logic and its records (zero to three) go into a
// four-entry record queue that drains one record per cycle while record_ready
// is high; char_ready is high while the queue holds at most one record, so a byte
// may be taken while a record still waits. a byte's records are written into the
// queue when it is accepted. a byte yielding two or three records (a parenthesis,
// or an atom ended by one) keeps char_ready low while the queue drains.
// when the receiver stalls, the queue fills and char_ready drops; nothing is lost.
// reset: the lexer returns to idle, the atom state clears and the queue empties.
module s_expression_lexer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  logic                 kind,
	input  logic [7:0]           char_code,
	output logic                 record_valid,
	input  logic                 record_ready,
	output logic                 record_kind,
	output logic [7:0]           token_byte,
	output logic [2:0]           token_class,
	output logic signed [31:0]   int_value,
	output logic                 bool_value,
	output logic [2:0]           error_code
);
	import sexl_pkg::*;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_ATOM   = 5'b00010,
		MODE_STRING = 5'b00100,
		MODE_CHAR   = 5'b01000,
		MODE_SKIP   = 5'b10000
	} mode_t;

	mode_t      mode_q, mode_nxt;
	logic [1:0] quoted_q, quoted_nxt;
	atom_t      atom_q, atom_nxt;
	logic [7:0] held_q, held_nxt;

	rec_t       recs [3];
	logic [1:0] n_rec;
	logic       do_idle;
	rec_t       fin;

	rec_t       fifo_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;

	logic in_acc, out_acc;

	assign char_ready   = (cnt_q <= 3'd1);
	assign in_acc       = char_valid && char_ready;
	assign record_valid = (cnt_q != 3'd0);
	assign out_acc      = record_valid && record_ready;

	// lex one input transaction against the current state
	always_comb begin
		mode_nxt   = mode_q;
		quoted_nxt = quoted_q;
		atom_nxt   = atom_q;
		held_nxt   = held_q;
		n_rec      = 2'd0;
		do_idle    = 1'b0;
		fin        = atom_finish(atom_q);
		for (int i = 0; i < 3; i++)
			recs[i] = '0;

		if (kind) begin
			// end of text closes any open token
			case (mode_q)
				MODE_ATOM: begin
					recs[n_rec] = fin;
					n_rec = n_rec + 2'd1;
				end
				MODE_STRING: begin
					recs[n_rec] = rec_make(1'b1, 8'd0, CLS_STRING, 32'sd0, 1'b0, ERR_OPEN_STR);
					n_rec = n_rec + 2'd1;
				end
				MODE_CHAR: begin
					recs[n_rec] = rec_make(1'b1, 8'd0, CLS_CHAR, 32'sd0, 1'b0, ERR_OPEN_CHAR);
					n_rec = n_rec + 2'd1;
				end
				default: ;
			endcase
			mode_nxt   = MODE_IDLE;
			quoted_nxt = 2'd0;
			atom_nxt   = atom_clear();
		end else begin
			case (mode_q)
				MODE_SKIP: ;
				MODE_STRING: begin
					if (char_code == CH_DQUOTE) begin
						recs[n_rec] = rec_make(1'b1, 8'd0, CLS_STRING, 32'sd0, 1'b0, ERR_OK);
						mode_nxt = MODE_IDLE;
					end else
						recs[n_rec] = rec_make(1'b0, char_code, CLS_OPEN, 32'sd0, 1'b0, ERR_OK);
					n_rec = n_rec + 2'd1;
				end
				MODE_CHAR: begin
					if (char_code == CH_SQUOTE) begin
						if (quoted_q == 2'd1) begin
							recs[n_rec] = rec_make(1'b1, held_q, CLS_CHAR, 32'sd0, 1'b0, ERR_OK);
							mode_nxt = MODE_IDLE;
						end else begin
							recs[n_rec] = rec_make(1'b1, 8'd0, CLS_CHAR, 32'sd0, 1'b0,
								ERR_CHAR_LEN);
							mode_nxt = MODE_SKIP;
						end
						quoted_nxt = 2'd0;
					end else begin
						if (quoted_q == 2'd0)
							held_nxt = char_code;
						if (quoted_q != 2'd3)
							quoted_nxt = quoted_q + 2'd1;
						recs[n_rec] = rec_make(1'b0, char_code, CLS_OPEN, 32'sd0, 1'b0, ERR_OK);
					end
					n_rec = n_rec + 2'd1;
				end
				MODE_ATOM: begin
					if (char_code inside {CH_SPACE, CH_OPEN, CH_CLOSE, CH_SQUOTE, CH_DQUOTE}) begin
						recs[n_rec] = fin;
						n_rec = n_rec + 2'd1;
						atom_nxt = atom_clear();
						if (fin.error_code != ERR_OK)
							mode_nxt = MODE_SKIP;
						else
							do_idle = 1'b1;
					end else begin
						atom_nxt = atom_push(atom_q, char_code);
						recs[n_rec] = rec_make(1'b0, char_code, CLS_OPEN, 32'sd0, 1'b0, ERR_OK);
						n_rec = n_rec + 2'd1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			// idle handling, also for the delimiter that ended an atom
			if (do_idle) begin
				mode_nxt = MODE_IDLE;
				if (char_code == CH_SPACE) begin
				end else if (char_code == CH_OPEN || char_code == CH_CLOSE) begin
					recs[n_rec] = rec_make(1'b0, char_code, CLS_OPEN, 32'sd0, 1'b0, ERR_OK);
					n_rec = n_rec + 2'd1;
					recs[n_rec] = rec_make(1'b1, 8'd0,
						(char_code == CH_OPEN) ? CLS_OPEN : CLS_CLOSE, 32'sd0, 1'b0, ERR_OK);
					n_rec = n_rec + 2'd1;
				end else if (char_code == CH_DQUOTE) begin
					mode_nxt = MODE_STRING;
				end else if (char_code == CH_SQUOTE) begin
					mode_nxt   = MODE_CHAR;
					quoted_nxt = 2'd0;
					held_nxt   = 8'd0;
				end else begin
					mode_nxt = MODE_ATOM;
					atom_nxt = atom_push(atom_clear(), char_code);
					recs[n_rec] = rec_make(1'b0, char_code, CLS_OPEN, 32'sd0, 1'b0, ERR_OK);
					n_rec = n_rec + 2'd1;
				end
			end
		end
	end

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			quoted_q <= 2'd0;
			atom_q   <= atom_clear();
			held_q   <= 8'd0;
		end else if (in_acc) begin
			mode_q   <= mode_nxt;
			quoted_q <= quoted_nxt;
			atom_q   <= atom_nxt;
			held_q   <= held_nxt;
		end
	end

	// record queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (in_acc)
				wr_ptr_q <= wr_ptr_q + n_rec;
			if (out_acc)
				rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + (in_acc ? {1'b0, n_rec} : 3'd0) - (out_acc ? 3'd1 : 3'd0);
		end
	end

	// record queue storage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < n_rec)
					fifo_q[wr_ptr_q + 2'(i)] <= recs[i];
			end
		end
	end

	// head of queue drives the output fields
	assign record_kind = fifo_q[rd_ptr_q].record_kind;
	assign token_byte  = fifo_q[rd_ptr_q].token_byte;
	assign token_class = fifo_q[rd_ptr_q].token_class;
	assign int_value   = fifo_q[rd_ptr_q].int_value;
	assign bool_value  = fifo_q[rd_ptr_q].bool_value;
	assign error_code  = fifo_q[rd_ptr_q].error_code;

endmodule

[src/sexl_checker.sv]
`include "s_expression_lexer_defines.svh"

// port-level checks on the lexer output channel
module sexl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               record_valid,
	input logic               record_ready,
	input logic               record_kind,
	input logic [7:0]         token_byte,
	input logic [2:0]         token_class,
	input logic signed [31:0] int_value,
	input logic               bool_value,
	input logic [2:0]         error_code
);
	import sexl_pkg::*;

	// a stalled record stays offered and unchanged
	`SEXL_ASSERT_NEXT(a_rec_hold, clk, arst_n, record_valid && !record_ready, record_valid && $stable({record_kind, token_byte, token_class, int_value, bool_value, error_code}))

	// token byte records carry only the byte
	`SEXL_ASSERT_IMPL(a_byte_clean, clk, arst_n, record_valid && !record_kind, token_class == CLS_OPEN && int_value == 32'sd0 && !bool_value && error_code == ERR_OK)

	// errors only appear on end records
	`SEXL_ASSERT_IMPL(a_err_end, clk, arst_n, record_valid && error_code != ERR_OK, record_kind && token_byte == 8'd0 && int_value == 32'sd0)

	// a true flag belongs to a bool end record
	`SEXL_ASSERT_IMPL(a_bool_cls, clk, arst_n, record_valid && bool_value, record_kind && token_class == CLS_BOOL)

	// a nonzero value belongs to an integer end record
	`SEXL_ASSERT_IMPL(a_int_cls, clk, arst_n, record_valid && int_value != 32'sd0, record_kind && token_class == CLS_INT && error_code == ERR_OK)

endmodule

bind s_expression_lexer sexl_checker u_sexl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.record_valid (record_valid),
	.record_ready (record_ready),
	.record_kind  (record_kind),
	.token_byte   (token_byte),
	.token_class  (token_class),
	.int_value    (int_value),
	.bool_value   (bool_value),
	.error_code   (error_code)
);
